/* sv/soundex_stream_encoder_assert.svh */
// Assertion macros shared by the encoder's checker.
// Needs no other file; each macro expands to one labeled concurrent assertion.
`ifndef SOUNDEX_STREAM_ENCODER_ASSERT_SVH
`define SOUNDEX_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sse_pkg.sv */
// Shared types, constants and character functions of the Soundex encoder.
// No dependencies; used by every module of the block.
package sse_pkg;

  localparam int NUM_DIGITS = 3;

  typedef logic [2:0] code_t;
  typedef logic [1:0] count_t;

  localparam code_t CODE_NONE = 3'd0;
  localparam logic [2:0] DIGIT_ASCII_HI = 3'b110;  // '0'..'6' are 6'b110xxx

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_letter;
    logic [5:0] digit_one;
    logic [5:0] digit_two;
    logic [5:0] digit_three;
  } out_item_t;

  function automatic logic [7:0] upcase(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= "a" && ch <= "z") begin
      res = ch - 8'd32;
    end
    return res;
  endfunction

  function automatic code_t letter_code(input logic [7:0] ch);
    code_t res;
    case (upcase(ch))
      "B", "F", "P", "V":                     res = 3'd1;
      "C", "G", "J", "K", "Q", "S", "X", "Z": res = 3'd2;
      "D", "T":                               res = 3'd3;
      "L":                                    res = 3'd4;
      "M", "N":                               res = 3'd5;
      "R":                                    res = 3'd6;
      default:                                res = CODE_NONE;
    endcase
    return res;
  endfunction

  function automatic logic [5:0] digit_ascii(input code_t c);
    return {DIGIT_ASCII_HI, c};
  endfunction

endpackage

/* sv/sse_input_stage.sv */
// Input register of the Soundex encoder: one request held per cycle while not stalled.
// Depends on sse_pkg for the request type.
module sse_input_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sse_pkg::in_item_t in_item,
  output logic              stg_valid,
  input  logic              stg_ready,
  output sse_pkg::in_item_t stg_item
);

  logic              valid_r;
  sse_pkg::in_item_t item_r;

  // Hold only while a request sits here and the encoder cannot take it.
  assign in_stall  = valid_r && !stg_ready;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* sv/sse_encode_stage.sv */
// Soundex accumulation state and result register.
// Depends on sse_pkg for types, the letter code table and digit formatting.
module sse_encode_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stg_valid,
  output logic               stg_ready,
  input  sse_pkg::in_item_t  stg_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sse_pkg::out_item_t out_item
);

  logic                  at_start_r, at_start_nxt;
  logic [7:0]            letter_r, letter_nxt;
  sse_pkg::code_t        prev_r, prev_nxt;
  sse_pkg::count_t       count_r, count_nxt;
  sse_pkg::code_t [2:0]  digits_r, digits_nxt;
  logic                  out_valid_r;
  sse_pkg::out_item_t    out_item_r, out_item_nxt;

  logic                  fire;
  sse_pkg::code_t        code;
  logic [7:0]            upd_letter;
  sse_pkg::code_t        upd_prev;
  sse_pkg::count_t       upd_count;
  sse_pkg::code_t [2:0]  upd_digits;

  // A non-final request never waits; a final one waits for the result slot.
  assign stg_ready = !stg_item.last || !out_valid_r || !out_stall;
  assign fire      = stg_valid && stg_ready;
  assign code      = sse_pkg::letter_code(stg_item.character);

  always_comb begin
    upd_letter = letter_r;
    upd_prev   = prev_r;
    upd_count  = count_r;
    upd_digits = digits_r;
    if (at_start_r) begin
      upd_letter = sse_pkg::upcase(stg_item.character);
      upd_prev   = code;
      upd_count  = '0;
      upd_digits = '0;
    end else if (count_r < 2'(sse_pkg::NUM_DIGITS) && code != sse_pkg::CODE_NONE
                 && code != prev_r) begin
      upd_digits[count_r] = code;
      upd_count           = count_r + 2'd1;
      upd_prev            = code;
    end
  end

  always_comb begin
    out_item_nxt.first_letter = upd_letter;
    out_item_nxt.digit_one    = sse_pkg::digit_ascii(upd_digits[0]);
    out_item_nxt.digit_two    = sse_pkg::digit_ascii(upd_digits[1]);
    out_item_nxt.digit_three  = sse_pkg::digit_ascii(upd_digits[2]);
  end

  always_comb begin
    at_start_nxt = at_start_r;
    letter_nxt   = letter_r;
    prev_nxt     = prev_r;
    count_nxt    = count_r;
    digits_nxt   = digits_r;
    if (fire) begin
      if (stg_item.last) begin
        at_start_nxt = 1'b1;
        letter_nxt   = '0;
        prev_nxt     = '0;
        count_nxt    = '0;
        digits_nxt   = '0;
      end else begin
        at_start_nxt = 1'b0;
        letter_nxt   = upd_letter;
        prev_nxt     = upd_prev;
        count_nxt    = upd_count;
        digits_nxt   = upd_digits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      letter_r    <= '0;
      prev_r      <= '0;
      count_r     <= '0;
      digits_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      at_start_r <= at_start_nxt;
      letter_r   <= letter_nxt;
      prev_r     <= prev_nxt;
      count_r    <= count_nxt;
      digits_r   <= digits_nxt;
      if (fire && stg_item.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stg_item.last) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/soundex_stream_encoder.sv */
// Soundex stream encoder: out_valid is registered from the final character
// accepted by the encode stage; throughput one character per cycle, set by the
// input register feeding the encode stage. A final character waits only while
// a result is held and stalled. rst_n is synchronous, active low: clears the
// pipeline valids and the name state, so the next character starts a new name.
// Depends on sse_pkg, sse_input_stage and sse_encode_stage.
module soundex_stream_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sse_pkg::out_item_t out_item
);

  // Input register to encode stage handshake.
  logic              stg_valid;
  logic              stg_ready;
  sse_pkg::in_item_t stg_item;

  // Stage 1: registers each request as it arrives; stalls only when the
  // encode stage refuses the request it holds.
  sse_input_stage u_input (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_item  (stg_item)
  );

  // Stage 2: letter code lookup, dedupe against the previous code, digit
  // append, and on the final character the padded code into the result
  // register. The name state then returns to its reset values.
  sse_encode_stage u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_item  (stg_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* sv/sse_checker.sv */
// Port-level checks of the Soundex encoder's result channel, bound to the top.
// Depends on sse_pkg and soundex_stream_encoder_assert.svh.
`include "soundex_stream_encoder_assert.svh"

module sse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input sse_pkg::out_item_t out_item
);

  logic held;
  logic digits_ok;
  logic pad_ok;
  logic repeat_ok;

  assign held = out_valid && out_stall;

  // Each digit is ASCII '0' to '6'
  assign digits_ok = (out_item.digit_one[5:3] == 3'b110) && (out_item.digit_one[2:0] != 3'd7)
    && (out_item.digit_two[5:3] == 3'b110) && (out_item.digit_two[2:0] != 3'd7)
    && (out_item.digit_three[5:3] == 3'b110) && (out_item.digit_three[2:0] != 3'd7);

  // Padding only trails the held digits
  assign pad_ok = (out_item.digit_two == 6'd48 || out_item.digit_one != 6'd48)
    && (out_item.digit_three == 6'd48 || out_item.digit_two != 6'd48);

  assign repeat_ok = (out_item.digit_two == 6'd48 || out_item.digit_two != out_item.digit_one)
    && (out_item.digit_three == 6'd48 || out_item.digit_three != out_item.digit_two);

  `SSE_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid && $stable(out_item), "result moved")
  `SSE_ASSERT_IMPLY(a_digit_range, clk, rst_n, out_valid, digits_ok, "digit out of range")
  `SSE_ASSERT_IMPLY(a_pad_order, clk, rst_n, out_valid, pad_ok, "padding before a digit")
  `SSE_ASSERT_IMPLY(a_no_repeat, clk, rst_n, out_valid, repeat_ok, "repeated adjacent digit")
  `SSE_ASSERT_IMPLY(a_reset_clear, clk, rst_n, $rose(rst_n), !out_valid, "valid after reset")

endmodule

bind soundex_stream_encoder sse_checker u_sse_checker (.*);

/* tb/sv/tb.sv */
// Testbench for soundex_stream_encoder: streams names one character per request and
// predicts each four-character code, checking every result in order, field by field.
// Depends on sse_pkg (types) and the encoder RTL.
module tb;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int MAX_WAIT     = 7;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int TAIL_CYCLES  = 8;     // spare clocks after the last code has come back
  // Soundex digit of 'A'..'Z', one ASCII digit per letter, 'A' leftmost
  localparam logic [8*26-1:0] LETTER_DIGITS = "01230120022455012623010202";

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sse_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sse_pkg::out_item_t out_item;

  soundex_stream_encoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Predictor state: one name in progress
  bit                 name_open = 1'b0;
  logic [7:0]         kept_letter;
  sse_pkg::code_t     last_code;
  sse_pkg::count_t    digits_held;
  sse_pkg::code_t     name_digits [sse_pkg::NUM_DIGITS];
  sse_pkg::out_item_t codes_due [$];   // expected codes, oldest first

  int fail_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int next_stall;
  bit calm = 1'b0;             // when set, neither side idles
  sse_pkg::out_item_t want_code;

  // Case fold: only 'a'..'z' move; every other byte passes through
  function automatic logic [7:0] fold_upper(input logic [7:0] ch);
    return (ch inside {["a":"z"]}) ? (ch ^ 8'h20) : ch;
  endfunction

  function automatic sse_pkg::code_t sound_digit(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] glyph;
    up = fold_upper(ch);
    if (up < "A" || up > "Z") return sse_pkg::CODE_NONE;
    glyph = LETTER_DIGITS[8 * (25 - (up - "A")) +: 8];
    return sse_pkg::code_t'(glyph - "0");
  endfunction

  function automatic logic [5:0] digit_char(input sse_pkg::code_t c);
    logic [7:0] full;
    full = "0" + c;
    return full[5:0];
  endfunction

  // Advance the predicted name state by one accepted character
  function automatic void encode_char(input sse_pkg::in_item_t req);
    sse_pkg::code_t     c;
    sse_pkg::out_item_t res;
    c = sound_digit(req.character);
    if (!name_open) begin
      // first character: kept as the letter, its code seeds the duplicate filter
      kept_letter = fold_upper(req.character);
      last_code = c;
      digits_held = '0;
      name_digits = '{default: sse_pkg::CODE_NONE};
      name_open = 1'b1;
    end else if (digits_held < sse_pkg::NUM_DIGITS) begin
      // zero codes are transparent: they neither append nor clear last_code
      if (c != sse_pkg::CODE_NONE && c != last_code) begin
        name_digits[digits_held] = c;
        digits_held = digits_held + 1'b1;
        last_code = c;
      end
    end
    if (req.last) begin
      res.first_letter = kept_letter;
      res.digit_one = digit_char(name_digits[0]);
      res.digit_two = digit_char(name_digits[1]);
      res.digit_three = digit_char(name_digits[2]);
      codes_due.push_back(res);
      name_open = 1'b0;
    end
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // One request: optional gap, then hold valid and payload until accepted.
  // Valid is only lowered inside a gap, so back-to-back requests keep it high.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= sse_pkg::in_item_t'{character: ch, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_char(sse_pkg::in_item_t'{character: ch, last: lst});
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Sender holds off until every pending code has come back
  task automatic wait_for_codes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_due.size() != 0) @(posedge clk);
  endtask

  // Mostly letters of both cases; now and then any byte at all
  function automatic logic [7:0] name_char();
    logic [7:0] base;
    base = 8'("A" + $urandom_range(0, 25));
    case ($urandom_range(0, 9))
      0:       return 8'($urandom);
      1, 2, 3: return base | 8'h20;
      default: return base;
    endcase
  endfunction

  // Well-formed names, mostly short, a few long enough to overrun three digits
  task automatic stream_names(input int budget, input bit steady);
    int         sent;
    int         len;
    logic [7:0] ch;
    sent = 0;
    while (sent < budget) begin
      calm = steady || ($urandom_range(0, 7) == 0);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        ch = (i == 0 && $urandom_range(0, 7) == 0) ? 8'($urandom) : name_char();
        send_char(ch, i == len - 1);
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  task automatic test_directed_names();
    send_word("Robert");      // repeated R code after b still appends: R163
    send_char("x", 1'b1);     // one-character name, lower case folded
    send_char(8'hFF, 1'b1);   // high byte kept as the letter, no digits
    send_word("Tymczak");     // adjacent same codes collapse, padded with '0'
    send_char(8'h80, 1'b0);   // high byte first, then a full code
    send_char("b", 1'b0);
    send_char(8'hFF, 1'b0);   // non-letter inside the name
    send_char("D", 1'b0);
    send_char("l", 1'b0);     // third digit: the rest is ignored
    send_char("M", 1'b0);
    send_char("r", 1'b1);
    send_char(8'h00, 1'b1);   // zero byte as a whole name
  endtask

  task automatic test_random_names(input int budget);
    stream_names(budget, 1'b0);
  endtask

  // Raw bytes with random name breaks: codes, case folding and last all random
  task automatic test_random_bytes(input int budget);
    for (int i = 0; i < budget; i++) begin
      send_char(8'($urandom), (i == budget - 1) || ($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic test_back_to_back(input int budget);
    stream_names(budget, 1'b1);
  endtask

  // Result side stall: after each accepted result, draw how long to hold off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      next_stall = draw_wait();
      stall_left <= next_stall;
      out_stall <= (next_stall != 0);
    end
  end

  // Result check against the oldest pending code
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (codes_due.size() == 0) begin
        report($sformatf("unexpected result %h", out_item));
      end else begin
        want_code = codes_due.pop_front();
        if (out_item.first_letter !== want_code.first_letter)
          report($sformatf("first_letter got %h want %h",
                           out_item.first_letter, want_code.first_letter));
        if (out_item.digit_one !== want_code.digit_one)
          report($sformatf("digit_one got %h want %h",
                           out_item.digit_one, want_code.digit_one));
        if (out_item.digit_two !== want_code.digit_two)
          report($sformatf("digit_two got %h want %h",
                           out_item.digit_two, want_code.digit_two));
        if (out_item.digit_three !== want_code.digit_three)
          report($sformatf("digit_three got %h want %h",
                           out_item.digit_three, want_code.digit_three));
      end
    end
  end

  // Watchdog: a long run with no request moving means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_names();
    wait_for_codes();
    test_random_names(520);
    wait_for_codes();
    test_random_bytes(120);
    test_back_to_back(60);
    wait_for_codes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (codes_due.size() != 0) report($sformatf("%0d codes never came", codes_due.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
